FILE: rtl/core/apms_pkg.sv
package apms_pkg;

   localparam int unsigned CHAR_W  = 21;
   localparam int unsigned SLOT_W  = 5;
   localparam int unsigned CFG_W   = 6;
   localparam int unsigned SCORE_W = 32;
   localparam int unsigned DIST_W  = 6;

   localparam logic CMD_PATTERN = 1'b0;
   localparam logic CMD_TEXT    = 1'b1;

   localparam logic REG_PATTERN_LENGTH = 1'b0;
   localparam logic REG_ERROR_LIMIT    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic valid;
      logic last;
   } cell_ctl_type;

endpackage

FILE: rtl/core/apms_pattern_ram.sv
module apms_pattern_ram #(
   parameter int unsigned DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic [apms_pkg::CHAR_W-1:0]         wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic [apms_pkg::CHAR_W-1:0]         rd_data
);

   logic [apms_pkg::CHAR_W-1:0] mem [DEPTH];
   logic [apms_pkg::CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/apms_column_ram.sv
module apms_column_ram #(
   parameter int unsigned DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  clear,
   input  logic                                  wr_en,
   input  logic [$clog2(DEPTH)-1:0]              wr_addr,
   input  logic [$clog2(DEPTH+1)-1:0]            wr_data,
   input  logic                                  rd_en,
   input  logic [$clog2(DEPTH)-1:0]              rd_addr,
   output logic [$clog2(DEPTH+1)-1:0]            rd_data
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned DW = $clog2(DEPTH + 1);

   // Row r of the column lives at address r-1; an entry never written
   // since the last clear holds its initial value r.
   logic [DW-1:0]    mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [DW-1:0]    mem_q_ff;
   logic             vld_q_ff;
   logic [AW-1:0]    addr_q_ff;

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff  <= mem[rd_addr];
         vld_q_ff  <= valid_ff[rd_addr];
         addr_q_ff <= rd_addr;
      end
   end

   assign rd_data = vld_q_ff ? mem_q_ff : DW'(addr_q_ff) + DW'(1);

endmodule

FILE: rtl/core/apms_cell_unit.sv
module apms_cell_unit #(
   parameter int unsigned DW = 6
) (
   input  logic [DW-1:0] up,
   input  logic [DW-1:0] diag,
   input  logic [DW-1:0] old,
   input  logic          mismatch,
   output logic [DW-1:0] fresh
);

   logic [DW:0] from_up;
   logic [DW:0] from_left;
   logic [DW:0] from_diag;
   logic [DW:0] least;

   always_comb begin
      from_up   = {1'b0, up} + (DW+1)'(1);
      from_left = {1'b0, old} + (DW+1)'(1);
      from_diag = {1'b0, diag} + (DW+1)'(mismatch);
      least     = from_up;
      if (from_left < least) begin
         least = from_left;
      end
      if (from_diag < least) begin
         least = from_diag;
      end
      fresh = least[DW-1:0];
   end

endmodule

FILE: rtl/core/approx_pattern_match_scorer.sv
// Approximate pattern match scorer.
// Pattern characters and text characters arrive on the req_ stream; req_tuser
// selects a pattern write (0) or a text character (1), and req_tlast marks the
// last text character of a record. Pattern writes give no result. Each text
// character gives one transfer on the rsp_ stream with the running score, the
// edit distance at the pattern length and a hit flag.
// A text character is taken while the block is idle; then each of the
// MAX_PATTERN rows passes through the single shared cell unit, which reads
// the column memory; then the read pipeline drains and the score is updated,
// which waits while the previous result is still not taken.
// req_tready is low while a character is in work. A finished result sits in
// the output register; the block takes the next item meanwhile and only waits
// before loading a new result while the previous one is still not taken.
// Reset clears the distance column, score and rsp_tvalid, sets pattern length
// to 1 and error limit to 0, and keeps the pattern table. The user must write
// configuration through csr_ while the block is idle; this is not enforced.
module approx_pattern_match_scorer #(
   parameter int unsigned MAX_PATTERN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // slot[4:0], char_code[25:5], zero fill
   input  logic        req_tuser,  // cmd
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // score[31:0], distance[37:32], zero fill
   output logic        rsp_tuser,  // hit
   output logic        rsp_tlast
);

   localparam int unsigned AW = $clog2(MAX_PATTERN);
   localparam int unsigned DW = $clog2(MAX_PATTERN + 1);
   localparam int unsigned CW = apms_pkg::CHAR_W;
   localparam int unsigned SW = apms_pkg::SCORE_W;

   apms_pkg::state_type state_ff, state_in;

   logic [apms_pkg::CFG_W-1:0]  pl_ff, pl_in;
   logic [apms_pkg::CFG_W-1:0]  el_ff, el_in;
   logic [AW-1:0]               rd_addr_ff, rd_addr_in;
   apms_pkg::cell_ctl_type      cmp_ff, cmp_in;
   logic [AW-1:0]               cmp_addr_ff, cmp_addr_in;
   logic [DW-1:0]               up_ff, up_in;
   logic [DW-1:0]               diag_ff, diag_in;
   logic [DW-1:0]               dist_ff, dist_in;
   logic [CW-1:0]               code_ff, code_in;
   logic                        last_ff, last_in;
   logic [SW-1:0]               score_ff, score_in;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   logic [SW-1:0]               rsp_score_ff, rsp_score_in;
   logic [apms_pkg::DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        req_xfer;
   logic [apms_pkg::SLOT_W-1:0] req_slot;
   logic [CW-1:0]               req_char;
   logic                        pat_wr_en;
   logic                        rd_en;
   logic                        col_clear;
   logic [CW-1:0]               pat_rd_data;
   logic [DW-1:0]               col_rd_data;
   logic [DW-1:0]               fresh;
   logic [DW-1:0]               act_len;
   logic                        hit;
   logic [SW-1:0]               add;
   logic [SW:0]                 sum;

   assign req_slot   = req_tdata[apms_pkg::SLOT_W-1:0];
   assign req_char   = req_tdata[apms_pkg::SLOT_W +: CW];
   assign req_tready = (state_ff == apms_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign pat_wr_en  = req_xfer && (req_tuser == apms_pkg::CMD_PATTERN)
                       && (32'(req_slot) < 32'(MAX_PATTERN));

   always_comb begin
      if (pl_ff == '0) begin
         act_len = DW'(1);
      end else if (32'(pl_ff) > 32'(MAX_PATTERN)) begin
         act_len = DW'(MAX_PATTERN);
      end else begin
         act_len = DW'(pl_ff);
      end
   end

   apms_pattern_ram #(
      .DEPTH (MAX_PATTERN)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pat_wr_en),
      .wr_addr (AW'(req_slot)),
      .wr_data (req_char),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (pat_rd_data)
   );

   apms_column_ram #(
      .DEPTH (MAX_PATTERN)
   ) u_column_ram (
      .clock   (clock),
      .reset   (reset),
      .clear   (col_clear),
      .wr_en   (cmp_ff.valid),
      .wr_addr (cmp_addr_ff),
      .wr_data (fresh),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (col_rd_data)
   );

   apms_cell_unit #(
      .DW (DW)
   ) u_cell_unit (
      .up       (up_ff),
      .diag     (diag_ff),
      .old      (col_rd_data),
      .mismatch (pat_rd_data != code_ff),
      .fresh    (fresh)
   );

   always_comb begin
      hit = 32'(dist_ff) <= 32'(el_ff);
      if (dist_ff == '0) begin
         add = (SW'(act_len) << 1) + SW'(act_len);
      end else begin
         add = SW'(act_len) - SW'(dist_ff);
      end
      sum = {1'b0, score_ff} + {1'b0, hit ? add : SW'(0)};
   end

   always_comb begin
      state_in      = state_ff;
      pl_in         = pl_ff;
      el_in         = el_ff;
      rd_addr_in    = rd_addr_ff;
      cmp_in        = '0;
      cmp_in.last   = cmp_ff.last;
      cmp_addr_in   = rd_addr_ff;
      up_in         = up_ff;
      diag_in       = diag_ff;
      dist_in       = dist_ff;
      code_in       = code_ff;
      last_in       = last_ff;
      score_in      = score_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_score_in  = rsp_score_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      col_clear     = 1'b0;

      if (csr_we) begin
         case (csr_index)
            apms_pkg::REG_PATTERN_LENGTH: pl_in = csr_wdata;
            apms_pkg::REG_ERROR_LIMIT:    el_in = csr_wdata;
            default:                      pl_in = pl_ff;
         endcase
      end

      if (cmp_ff.valid) begin
         up_in   = fresh;
         diag_in = col_rd_data;
         if (32'(cmp_addr_ff) + 32'd1 == 32'(act_len)) begin
            dist_in = fresh;
         end
      end

      case (state_ff)
         apms_pkg::ST_IDLE: begin
            if (req_xfer && (req_tuser == apms_pkg::CMD_TEXT)) begin
               code_in    = req_char;
               last_in    = req_tlast;
               rd_addr_in = '0;
               up_in      = '0;
               diag_in    = '0;
               state_in   = apms_pkg::ST_SWEEP;
            end
         end
         apms_pkg::ST_SWEEP: begin
            rd_en        = 1'b1;
            cmp_in.valid = 1'b1;
            cmp_in.last  = 32'(rd_addr_ff) == 32'(MAX_PATTERN - 1);
            if (cmp_in.last) begin
               state_in = apms_pkg::ST_DRAIN;
            end else begin
               rd_addr_in = rd_addr_ff + AW'(1);
            end
         end
         apms_pkg::ST_DRAIN: begin
            state_in = apms_pkg::ST_FINISH;
         end
         apms_pkg::ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_score_in  = sum[SW] ? {SW{1'b1}} : sum[SW-1:0];
               if (32'(dist_ff) > 32'd63) begin
                  rsp_dist_in = 6'd63;
               end else begin
                  rsp_dist_in = apms_pkg::DIST_W'(dist_ff);
               end
               rsp_hit_in  = hit;
               rsp_last_in = last_ff;
               score_in    = last_ff ? SW'(0) : rsp_score_in;
               col_clear   = last_ff;
               state_in    = apms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = apms_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= apms_pkg::ST_IDLE;
         pl_ff         <= apms_pkg::CFG_W'(1);
         el_ff         <= '0;
         cmp_ff        <= '0;
         score_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pl_ff         <= pl_in;
         el_ff         <= el_in;
         cmp_ff        <= cmp_in;
         score_ff      <= score_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff   <= rd_addr_in;
      cmp_addr_ff  <= cmp_addr_in;
      up_ff        <= up_in;
      diag_ff      <= diag_in;
      dist_ff      <= dist_in;
      code_ff      <= code_in;
      last_ff      <= last_in;
      rsp_score_ff <= rsp_score_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_dist_ff, rsp_score_ff};
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
